@@ hdl/utf8_byte_stream_decoder_macros.svh @@
// Assertion macros used by the port-level checker of the UTF-8 byte decoder.
// Depends on a clock named clk and an active-high reset named rst in the using scope.
`ifndef UTF8_BYTE_STREAM_DECODER_MACROS_SVH
`define UTF8_BYTE_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, skipped while in reset.
`define UBSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, skipped while in reset.
`define UBSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define UBSD_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ubsd_pkg.sv @@
// Package for the UTF-8 byte decoder: lead byte classes, masks and the classifier.
// No dependencies.
package ubsd_pkg;

  localparam int unsigned CP_W    = 31;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEFT_W  = 3;
  localparam int unsigned START_W = 5;
  localparam int unsigned CONT_W  = 6;

  typedef logic [CP_W-1:0]    cp_t;
  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [LEFT_W-1:0]  left_t;
  typedef logic [START_W-1:0] start_t;

  localparam byte_t CONT_MASK = 8'h3F;

  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_FIVE,
    LEAD_SIX,
    LEAD_BAD
  } lead_class_t;

  typedef struct packed {
    lead_class_t cls;
    left_t       extra;
    start_t      start;
  } lead_info_t;

  function automatic lead_info_t classify(input byte_t b);
    lead_info_t info;
    info.cls   = LEAD_BAD;
    info.extra = '0;
    info.start = '0;
    if (b[7] == 1'b0) begin
      info.cls = LEAD_ASCII;
    end else if ((b & 8'hE0) == 8'hC0) begin
      info.cls   = LEAD_TWO;
      info.extra = 3'd1;
      info.start = b[4:0];
    end else if ((b & 8'hF0) == 8'hE0) begin
      info.cls   = LEAD_THREE;
      info.extra = 3'd2;
      info.start = {1'b0, b[3:0]};
    end else if ((b & 8'hF8) == 8'hF0) begin
      info.cls   = LEAD_FOUR;
      info.extra = 3'd3;
      info.start = {2'b0, b[2:0]};
    end else if ((b & 8'hFC) == 8'hF8) begin
      info.cls   = LEAD_FIVE;
      info.extra = 3'd4;
      info.start = {3'b0, b[1:0]};
    end else if ((b & 8'hFE) == 8'hFC) begin
      info.cls   = LEAD_SIX;
      info.extra = 3'd5;
      info.start = {4'b0, b[0]};
    end
    return info;
  endfunction

endpackage

@@ hdl/utf8_byte_stream_decoder.sv @@
// A result shows in the output register in the cycle after its last byte is accepted.
// Throughput: one byte per cycle; in_ready drops only while a held result is not taken.
// The sequence state (partial value, bytes left) and the output register update in one pass.
// Reset (synchronous, rst high): empty output register, no open sequence, partial value 0.
// Lead byte classification and masks come from ubsd_pkg.
module utf8_byte_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] code_point,
  output logic        bad_lead
);

  // Sequence state.
  ubsd_pkg::cp_t   partial_value;
  ubsd_pkg::cp_t   partial_value_next;
  ubsd_pkg::left_t bytes_left;
  ubsd_pkg::left_t bytes_left_next;

  // Output register.
  logic            res_valid;
  logic            res_valid_next;
  ubsd_pkg::cp_t   res_cp;
  ubsd_pkg::cp_t   res_cp_next;
  logic            res_bad;
  logic            res_bad_next;

  logic                 in_xact;
  logic                 emit;
  ubsd_pkg::lead_info_t lead;
  ubsd_pkg::cp_t        shifted;
  ubsd_pkg::byte_t      cont_bits;

  // Take a new byte whenever the output register is empty or drains this cycle.
  assign in_ready = !res_valid || out_ready;
  assign in_xact  = in_valid && in_ready;

  assign lead      = ubsd_pkg::classify(byte_in);
  assign cont_bits = byte_in & ubsd_pkg::CONT_MASK;
  // Shift in the low six bits; the top bits fall off the 31-bit value.
  assign shifted   = {partial_value[ubsd_pkg::CP_W-ubsd_pkg::CONT_W-1:0],
                      cont_bits[ubsd_pkg::CONT_W-1:0]};

  always_comb begin
    partial_value_next = partial_value;
    bytes_left_next    = bytes_left;
    emit               = 1'b0;
    res_cp_next        = res_cp;
    res_bad_next       = res_bad;
    if (in_xact) begin
      if (bytes_left != '0) begin
        // Inside a sequence: every byte counts as a continuation byte.
        bytes_left_next = bytes_left - 3'd1;
        if (bytes_left == 3'd1) begin
          emit               = 1'b1;
          res_cp_next        = shifted;
          res_bad_next       = 1'b0;
          partial_value_next = '0;
        end else begin
          partial_value_next = shifted;
        end
      end else begin
        case (lead.cls)
          ubsd_pkg::LEAD_ASCII: begin
            emit         = 1'b1;
            res_cp_next  = {{(ubsd_pkg::CP_W-ubsd_pkg::BYTE_W){1'b0}}, byte_in};
            res_bad_next = 1'b0;
          end
          ubsd_pkg::LEAD_BAD: begin
            // Stray continuation byte or 0xFE/0xFF: flag it, keep the state.
            emit         = 1'b1;
            res_cp_next  = '0;
            res_bad_next = 1'b1;
          end
          default: begin
            // Open a multi-byte sequence with its masked start value.
            partial_value_next = {{(ubsd_pkg::CP_W-ubsd_pkg::START_W){1'b0}}, lead.start};
            bytes_left_next    = lead.extra;
          end
        endcase
      end
    end
  end

  always_comb begin
    res_valid_next = res_valid;
    if (emit) begin
      res_valid_next = 1'b1;
    end else if (out_ready) begin
      res_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value <= '0;
      bytes_left    <= '0;
      res_valid     <= 1'b0;
    end else begin
      partial_value <= partial_value_next;
      bytes_left    <= bytes_left_next;
      res_valid     <= res_valid_next;
    end
  end

  // Payload: load only with a new result, hold otherwise.
  always_ff @(posedge clk) begin
    if (emit) begin
      res_cp  <= res_cp_next;
      res_bad <= res_bad_next;
    end
  end

  assign out_valid  = res_valid;
  assign code_point = res_cp;
  assign bad_lead   = res_bad;

endmodule

@@ hdl/ubsd_checker.sv @@
// Port-level checker for the UTF-8 byte decoder, bound to the top level.
// Depends on utf8_byte_stream_decoder_macros.svh.
`include "utf8_byte_stream_decoder_macros.svh"

module ubsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [30:0] code_point,
  input logic        bad_lead
);

  `UBSD_ASSERT_NOW(a_bad_is_zero, out_valid && bad_lead, code_point == 31'd0, "flagged result carries a nonzero code point")
  `UBSD_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with an empty output")
  `UBSD_ASSERT_ALWAYS(a_reset_empty, rst, !out_valid, "output valid right after reset")
  `UBSD_ASSERT_NEXT(a_hold_stall, out_valid && !out_ready, out_valid && $stable(code_point) && $stable(bad_lead), "stalled result changed")

endmodule

bind utf8_byte_stream_decoder ubsd_checker u_ubsd_checker (.*);

@@ verif/tb_top.sv @@
// Self-checking testbench for utf8_byte_stream_decoder: random and directed byte streams.
// Predicts every code point and bad-lead flag on its own and compares each output transaction.
// Depends on ubsd_pkg (byte, code point and lead class types) and the decoder RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned HOLD_OFF_CYCLES = 150;
  localparam int unsigned PHASE_BYTES     = 200;
  localparam int unsigned SETTLE_CYCLES   = 8;

  // One expected output transaction.
  typedef struct {
    ubsd_pkg::cp_t cp;
    logic          bad;
  } decoded_char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  byte_in = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [30:0] code_point;
  logic        bad_lead;

  utf8_byte_stream_decoder DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_in    (byte_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_point (code_point),
    .bad_lead   (bad_lead)
  );

  // Bytes waiting to be offered, and code points the decoder still owes us.
  ubsd_pkg::byte_t tx_bytes[$];
  decoded_char_t   expected_chars[$];

  // Shadow of the decoder's sequence state.
  ubsd_pkg::cp_t   seq_value = '0;
  ubsd_pkg::left_t seq_left  = '0;

  // Idle rates in percent, changed per phase by the stimulus process.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Long receiver hold-off: requested by the stimulus, counted by the receiver.
  int unsigned hold_off_requests = 0;
  int unsigned hold_off_served = 0;
  int unsigned hold_left = 0;

  int unsigned cycle_count = 0;
  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned chars_checked = 0;
  int unsigned bad_checked = 0;
  logic        take;

  // Directed opening: ASCII extremes, stray continuation, 0xFE/0xFF, one sequence of each
  // length; the five- and six-byte ones carry continuation bytes whose high bits look like
  // lead bytes, and the six-byte one fills all 31 bits.
  ubsd_pkg::byte_t directed_bytes[25] = '{
    8'h00, 8'h7F, 8'h80, 8'hFE, 8'hFF,
    8'hC2, 8'hA9,
    8'hE2, 8'h82, 8'hAC,
    8'hF0, 8'h9F, 8'h98, 8'h80,
    8'hFB, 8'hC0, 8'h00, 8'h40, 8'h80,
    8'hFD, 8'hFF, 8'h7F, 8'hBF, 8'h3F, 8'hFF
  };

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Advance the shadow decoder by one accepted byte; queue a code point when one completes.
  task automatic decode_byte(input ubsd_pkg::byte_t b);
    ubsd_pkg::lead_class_t cls;
    ubsd_pkg::cp_t         start;
    ubsd_pkg::left_t       extra;
    decoded_char_t         item;
    cls   = ubsd_pkg::LEAD_BAD;
    start = '0;
    extra = '0;
    if (seq_left != '0) begin
      // Open sequence: every byte is a continuation, only its low six bits count.
      seq_value = {seq_value[ubsd_pkg::CP_W-7:0], b[5:0]};
      seq_left  = seq_left - 1'b1;
      if (seq_left == '0) begin
        item.cp  = seq_value;
        item.bad = 1'b0;
        expected_chars.push_back(item);
        seq_value = '0;
      end
    end else begin
      casez (b)
        8'b0???????: cls = ubsd_pkg::LEAD_ASCII;
        8'b110?????: begin
          cls = ubsd_pkg::LEAD_TWO;   start = ubsd_pkg::cp_t'(b[4:0]); extra = 3'd1;
        end
        8'b1110????: begin
          cls = ubsd_pkg::LEAD_THREE; start = ubsd_pkg::cp_t'(b[3:0]); extra = 3'd2;
        end
        8'b11110???: begin
          cls = ubsd_pkg::LEAD_FOUR;  start = ubsd_pkg::cp_t'(b[2:0]); extra = 3'd3;
        end
        8'b111110??: begin
          cls = ubsd_pkg::LEAD_FIVE;  start = ubsd_pkg::cp_t'(b[1:0]); extra = 3'd4;
        end
        8'b1111110?: begin
          cls = ubsd_pkg::LEAD_SIX;   start = ubsd_pkg::cp_t'(b[0]);   extra = 3'd5;
        end
        default:     cls = ubsd_pkg::LEAD_BAD;
      endcase
      case (cls)
        ubsd_pkg::LEAD_ASCII: begin
          item.cp  = ubsd_pkg::cp_t'(b);
          item.bad = 1'b0;
          expected_chars.push_back(item);
        end
        ubsd_pkg::LEAD_BAD: begin
          // Stray continuation or 0xFE/0xFF: flag it, keep the state as it is.
          item.cp  = '0;
          item.bad = 1'b1;
          expected_chars.push_back(item);
        end
        default: begin
          seq_value = start;
          seq_left  = extra;
        end
      endcase
    end
  endtask

  // Queue one sequence of the given length with random payload bits. With sloppy set,
  // some continuation bytes get random high bits, which the decoder must ignore.
  task automatic queue_sequence(input int unsigned len, input bit sloppy, input int unsigned cut);
    ubsd_pkg::byte_t lead;
    ubsd_pkg::byte_t tail;
    case (len)
      1:       lead = {1'b0, 7'($urandom)};
      2:       lead = {3'b110, 5'($urandom)};
      3:       lead = {4'b1110, 4'($urandom)};
      4:       lead = {5'b11110, 3'($urandom)};
      5:       lead = {6'b111110, 2'($urandom)};
      default: lead = {7'b1111110, 1'($urandom)};
    endcase
    tx_bytes.push_back(lead);
    for (int i = 1; i < len - cut; i++) begin
      tail = {2'b10, 6'($urandom)};
      if (sloppy && $urandom_range(3) == 0) tail[7:6] = 2'($urandom);
      tx_bytes.push_back(tail);
    end
  endtask

  // Fill the queue with mostly well-formed sequences, some truncated ones and raw noise.
  task automatic fill_random(input int unsigned count);
    int unsigned pick;
    int unsigned len;
    while (tx_bytes.size() < count) begin
      pick = $urandom_range(99);
      len  = $urandom_range(6, 1);
      if (pick < 70) begin
        queue_sequence(len, 1'b1, 0);
      end else if (pick < 85) begin
        tx_bytes.push_back(ubsd_pkg::byte_t'($urandom));
      end else begin
        // Broken sequence: drop one or more continuation bytes.
        if (len < 2) len = 2;
        queue_sequence(len, 1'b0, $urandom_range(len - 1, 1));
      end
    end
  endtask

  // Pause the sender until every byte is taken and every owed code point has come out.
  task automatic drain;
    while (tx_bytes.size() != 0 || in_valid) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: one byte per transaction, valid held until accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      take = in_valid && in_ready;
      if (take) begin
        decode_byte(byte_in);
        bytes_sent++;
      end
      if (!in_valid || take) begin
        if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          byte_in  <= tx_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each output transaction against the oldest expectation, then pick
  // the next ready level (long hold-off first, random stalls otherwise).
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected output transaction: code_point %h bad_lead %b",
                 code_point, bad_lead);
          errors++;
        end else begin
          if (code_point !== expected_chars[0].cp) begin
            $error("code_point mismatch: expected %h, actual %h",
                   expected_chars[0].cp, code_point);
            errors++;
          end
          if (bad_lead !== expected_chars[0].bad) begin
            $error("bad_lead mismatch: expected %b, actual %b",
                   expected_chars[0].bad, bad_lead);
            errors++;
          end
          if (expected_chars[0].bad) bad_checked++;
          chars_checked++;
          void'(expected_chars.pop_front());
        end
      end
      if (hold_off_served < hold_off_requests) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_off_served++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d code points still owed",
             cycle_count, expected_chars.size());
    $display("== FAIL ==");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Phase 1: sender rarely idles, receiver mostly stalls.
    send_idle_pct  = 9;
    recv_stall_pct = 80;
    foreach (directed_bytes[i]) tx_bytes.push_back(directed_bytes[i]);
    fill_random(PHASE_BYTES);
    drain();

    // Phase 2: the other way round.
    send_idle_pct  = 80;
    recv_stall_pct = 9;
    fill_random(PHASE_BYTES);
    drain();

    // Phase 3: no idling; start with a long hold-off so the output fills and stalls the input.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_requests++;
    fill_random(PHASE_BYTES);
    // End inside an open sequence: nothing may come out for it.
    tx_bytes.push_back(8'hE2);
    tx_bytes.push_back(8'h82);
    drain();

    if (expected_chars.size() != 0) begin
      $error("%0d expected code points never arrived", expected_chars.size());
      errors++;
    end
    $display("Sent %0d bytes under three idle patterns and one long output hold-off;",
             bytes_sent);
    $display("checked %0d output transactions, %0d of them flagged bad_lead, %0d errors.",
             chars_checked, bad_checked, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
